@@ rtl/vad_pkg.sv @@
// Shared types, constants and elaboration-time trig tables for the vector angle block.
package vad_pkg;

  localparam int NDEG      = 45;
  localparam int IDX_W     = 6;
  localparam int FRAC_W    = 128;
  localparam int LIMB_W    = 32;
  localparam int NLIMB     = FRAC_W / LIMB_W;
  localparam int ANG_W     = 9;
  localparam int SEARCH_STEPS = 6;

  localparam logic [ANG_W-1:0] ANG_0   = 9'd0;
  localparam logic [ANG_W-1:0] ANG_45  = 9'd45;
  localparam logic [ANG_W-1:0] ANG_89  = 9'd89;
  localparam logic [ANG_W-1:0] ANG_90  = 9'd90;
  localparam logic [ANG_W-1:0] ANG_179 = 9'd179;
  localparam logic [ANG_W-1:0] ANG_180 = 9'd180;
  localparam logic [ANG_W-1:0] ANG_270 = 9'd270;
  localparam logic [ANG_W-1:0] ANG_359 = 9'd359;
  localparam logic [ANG_W-1:0] ANG_360 = 9'd360;

  localparam logic [FRAC_W-1:0] PI_FRAC = 128'h243F6A8885A308D313198A2E03707344;

  typedef logic [NDEG-1:0][FRAC_W-1:0] trig_tab_t;

  // Side information that travels with an item from the fold to the unfold stage.
  typedef struct packed {
    logic             special;
    logic [ANG_W-1:0] special_angle;
    logic             diag;
    logic             steep;
    logic             xneg;
    logic             yneg;
  } side_t;

  // Upper half of a Q0.128 by Q0.128 product.
  function automatic logic [FRAC_W-1:0] fx_mul(input logic [FRAC_W-1:0] a,
                                               input logic [FRAC_W-1:0] b);
    logic [2*FRAC_W-1:0] p;
    p = {{FRAC_W{1'b0}}, a} * {{FRAC_W{1'b0}}, b};
    return p[2*FRAC_W-1:FRAC_W];
  endfunction

  // (whole + a) / d by restoring long division, one quotient bit per pass.
  function automatic logic [FRAC_W-1:0] fx_div(input logic [31:0] whole,
                                               input logic [FRAC_W-1:0] a,
                                               input logic [31:0] d);
    logic [FRAC_W+31:0] num;
    logic [FRAC_W+31:0] q;
    logic [32:0]        rem;
    num = {whole, a};
    q   = '0;
    rem = '0;
    for (int i = FRAC_W + 31; i >= 0; i--) begin
      rem = {rem[31:0], num[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q[FRAC_W-1:0];
  endfunction

  // Builds cos(k) or sin(k) for k = 1..44 degrees as Q0.128 fractions; entry 0 is zero in both tables.
  function automatic trig_tab_t build_trig(input logic want_sin);
    logic [FRAC_W-1:0] th;
    logic [FRAC_W-1:0] th2;
    logic [FRAC_W-1:0] term;
    logic [FRAC_W-1:0] sum;
    logic [FRAC_W-1:0] w;
    logic [FRAC_W-1:0] t1;
    logic [FRAC_W-1:0] t2;
    trig_tab_t         c;
    trig_tab_t         s;
    th   = fx_div(32'd3, PI_FRAC, 32'd180);
    th2  = fx_mul(th, th);
    sum  = th;
    term = th;
    for (int n = 1; n <= 39; n += 2) begin
      t1   = fx_mul(term, th2);
      term = fx_div(32'd0, t1, 32'((n + 1) * (n + 2)));
      if ((((n + 1) / 2) % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    s    = '0;
    c    = '0;
    s[1] = sum;
    term = fx_div(32'd0, th2, 32'd2);
    w    = term;
    for (int n = 2; n <= 20; n++) begin
      t1   = fx_mul(term, th2);
      term = fx_div(32'd0, t1, 32'((2 * n - 1) * (2 * n)));
      if ((n % 2) == 0) w = w - term;
      else w = w + term;
    end
    c[1] = '0 - w;
    for (int k = 2; k < NDEG; k++) begin
      t1   = fx_mul(c[k-1], c[1]);
      t2   = fx_mul(s[k-1], s[1]);
      c[k] = t1 - t2;
      t1   = fx_mul(s[k-1], c[1]);
      t2   = fx_mul(c[k-1], s[1]);
      s[k] = t1 + t2;
    end
    return want_sin ? s : c;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage

@@ rtl/vad_fold.sv @@
// Input stage: takes magnitudes, folds the point into the first octant, flags axis points.
module vad_fold #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_WIDTH-1:0]    x_coord,
  input  logic [COORD_WIDTH-1:0]    y_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COORD_WIDTH-1:0]    u,
  output logic [COORD_WIDTH-1:0]    v,
  output vad_pkg::side_t            side
);

  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic                   xneg;
  logic                   yneg;
  vad_pkg::side_t         side_next;

  assign xneg = x_coord[COORD_WIDTH-1];
  assign yneg = y_coord[COORD_WIDTH-1];
  // The most negative value negates to itself, which read unsigned is the right magnitude.
  assign ax = xneg ? (~x_coord + 1'b1) : x_coord;
  assign ay = yneg ? (~y_coord + 1'b1) : y_coord;

  always_comb begin
    side_next.special       = 1'b0;
    side_next.special_angle = vad_pkg::ANG_0;
    side_next.diag          = (ax == ay);
    side_next.steep         = (ay > ax);
    side_next.xneg          = xneg;
    side_next.yneg          = yneg;
    if (ay == '0) begin
      side_next.special       = 1'b1;
      side_next.diag          = 1'b0;
      side_next.special_angle = xneg ? vad_pkg::ANG_180 : vad_pkg::ANG_0;
    end else if (ax == '0) begin
      side_next.special       = 1'b1;
      side_next.diag          = 1'b0;
      side_next.special_angle = yneg ? vad_pkg::ANG_270 : vad_pkg::ANG_90;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      u    <= (ax > ay) ? ax : ay;
      v    <= (ax > ay) ? ay : ax;
      side <= side_next;
    end
  end

  a_diag_not_special: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(side.diag && side.special))
    else $error("diagonal flag set on an axis point");

  a_fold_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (u >= v))
    else $error("folded pair out of order");

  a_diag_equal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && side.diag) |-> (u == v))
    else $error("diagonal flag without equal magnitudes");

endmodule

@@ rtl/vad_search_step.sv @@
// One binary-search step over whole degrees: partial products, then sum and sign compare.
module vad_search_step #(
  parameter int COORD_WIDTH = 16,
  parameter int STEP_BIT    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_WIDTH-1:0]            u_in,
  input  logic [COORD_WIDTH-1:0]            v_in,
  input  logic [vad_pkg::IDX_W-1:0]         f_in,
  input  vad_pkg::side_t                    side_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_WIDTH-1:0]            u_out,
  output logic [COORD_WIDTH-1:0]            v_out,
  output logic [vad_pkg::IDX_W-1:0]         f_out,
  output vad_pkg::side_t                    side_out
);

  localparam int PP_W  = vad_pkg::LIMB_W + COORD_WIDTH;
  localparam int SUM_W = vad_pkg::FRAC_W + COORD_WIDTH;

  logic [vad_pkg::IDX_W:0]               cand;
  logic                                  cand_ok;
  logic [vad_pkg::IDX_W-1:0]             idx;
  logic [vad_pkg::FRAC_W-1:0]            cos_k;
  logic [vad_pkg::FRAC_W-1:0]            sin_k;
  logic [vad_pkg::NLIMB-1:0][PP_W-1:0]   lhs_pp_next;
  logic [vad_pkg::NLIMB-1:0][PP_W-1:0]   rhs_pp_next;

  // Stage A registers.
  logic                                  a_valid;
  logic                                  a_ready;
  logic [vad_pkg::NLIMB-1:0][PP_W-1:0]   lhs_pp;
  logic [vad_pkg::NLIMB-1:0][PP_W-1:0]   rhs_pp;
  logic                                  a_cand_ok;
  logic [vad_pkg::IDX_W-1:0]             a_idx;
  logic [COORD_WIDTH-1:0]                a_u;
  logic [COORD_WIDTH-1:0]                a_v;
  logic [vad_pkg::IDX_W-1:0]             a_f;
  vad_pkg::side_t                        a_side;

  logic [SUM_W-1:0]                      lhs;
  logic [SUM_W-1:0]                      rhs;
  logic [vad_pkg::IDX_W-1:0]             f_next;

  assign cand    = {1'b0, f_in} + (vad_pkg::IDX_W+1)'(1 << STEP_BIT);
  assign cand_ok = (cand <= (vad_pkg::IDX_W+1)'(vad_pkg::NDEG - 1));
  assign idx     = cand_ok ? cand[vad_pkg::IDX_W-1:0] : '0;
  assign cos_k   = vad_pkg::COS_TAB[idx];
  assign sin_k   = vad_pkg::SIN_TAB[idx];

  always_comb begin
    for (int i = 0; i < vad_pkg::NLIMB; i++) begin
      lhs_pp_next[i] = PP_W'(cos_k[i*vad_pkg::LIMB_W +: vad_pkg::LIMB_W]) * PP_W'(v_in);
      rhs_pp_next[i] = PP_W'(sin_k[i*vad_pkg::LIMB_W +: vad_pkg::LIMB_W]) * PP_W'(u_in);
    end
  end

  always_comb begin
    lhs = '0;
    rhs = '0;
    for (int i = 0; i < vad_pkg::NLIMB; i++) begin
      lhs = lhs + (SUM_W'(lhs_pp[i]) << (i * vad_pkg::LIMB_W));
      rhs = rhs + (SUM_W'(rhs_pp[i]) << (i * vad_pkg::LIMB_W));
    end
  end

  // The octant angle exceeds the candidate degree exactly when v*cos(k) > u*sin(k).
  assign f_next = (a_cand_ok && (lhs > rhs)) ? a_idx : a_f;

  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
    end
    if (in_ready && in_valid) begin
      lhs_pp    <= lhs_pp_next;
      rhs_pp    <= rhs_pp_next;
      a_cand_ok <= cand_ok;
      a_idx     <= idx;
      a_u       <= u_in;
      a_v       <= v_in;
      a_f       <= f_in;
      a_side    <= side_in;
    end
    if (a_ready && a_valid) begin
      u_out    <= a_u;
      v_out    <= a_v;
      f_out    <= f_next;
      side_out <= a_side;
    end
  end

  a_f_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (f_out <= vad_pkg::IDX_W'(vad_pkg::NDEG - 1)))
    else $error("degree index beyond the table");

  a_cand_index: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_cand_ok) |-> (a_idx > a_f))
    else $error("candidate degree not above the running floor");

  a_step_monotone: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_ready) |=> (f_out >= $past(a_f)))
    else $error("search step lowered the running floor");

endmodule

@@ rtl/vad_unfold.sv @@
// Output stage: maps the octant degree back to the full circle and holds the result.
module vad_unfold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vad_pkg::IDX_W-1:0]     f_in,
  input  vad_pkg::side_t                side_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vad_pkg::ANG_W-1:0]     angle_deg
);

  logic [vad_pkg::ANG_W-1:0] a;
  logic [vad_pkg::ANG_W-1:0] angle_next;

  always_comb begin
    if (side_in.diag) a = vad_pkg::ANG_45;
    else if (side_in.steep) a = vad_pkg::ANG_89 - vad_pkg::ANG_W'(f_in);
    else a = vad_pkg::ANG_W'(f_in);

    if (side_in.special) begin
      angle_next = side_in.special_angle;
    end else if (!side_in.xneg && !side_in.yneg) begin
      angle_next = a;
    end else if (side_in.xneg && !side_in.yneg) begin
      angle_next = (side_in.diag ? vad_pkg::ANG_180 : vad_pkg::ANG_179) - a;
    end else if (side_in.xneg) begin
      angle_next = vad_pkg::ANG_180 + a;
    end else begin
      angle_next = (side_in.diag ? vad_pkg::ANG_360 : vad_pkg::ANG_359) - a;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      angle_deg <= angle_next;
    end
  end

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg < vad_pkg::ANG_360))
    else $error("angle outside 0 to 359");

  a_diag_exact: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && side_in.diag) |=>
      (angle_deg == vad_pkg::ANG_45 || angle_deg == 9'd135 ||
       angle_deg == 9'd225 || angle_deg == 9'd315))
    else $error("diagonal point not on a multiple of 45 degrees");

  a_special_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && side_in.special) |=> (angle_deg == $past(side_in.special_angle)))
    else $error("axis point angle altered");

endmodule

@@ rtl/vector_angle_degrees.sv @@
// Direction of a point (x, y) from the origin in whole degrees, floored, 0 to 359.
// One item enters per cycle when not stalled by backpressure. Stages: one fold stage, six
// binary-search steps of two stages each (partial products of the coordinate with a
// 128-bit cos or sin constant, then the wide sum and sign compare), and one unfold stage
// that drives the output register. The compare against each whole degree is exact, so axis
// points and diagonals come out on 0, 45, 90 and so on. Backpressure stalls the pipeline
// stage by stage; empty stages keep filling while a result waits.
module vector_angle_degrees #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_coord, then y_coord, zero padded to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // angle_deg, zero padded to whole bytes
  output logic [15:0]                           m_axis_tdata
);

  localparam int NSTEP = vad_pkg::SEARCH_STEPS;

  logic [NSTEP:0]                         st_valid;
  logic [NSTEP:0]                         st_ready;
  logic [NSTEP:0][COORD_WIDTH-1:0]        st_u;
  logic [NSTEP:0][COORD_WIDTH-1:0]        st_v;
  logic [NSTEP:0][vad_pkg::IDX_W-1:0]     st_f;
  vad_pkg::side_t [NSTEP:0]               st_side;
  logic [vad_pkg::ANG_W-1:0]              angle_deg;

  vad_fold #(.COORD_WIDTH(COORD_WIDTH)) u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .x_coord   (s_axis_tdata[COORD_WIDTH-1:0]),
    .y_coord   (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .u         (st_u[0]),
    .v         (st_v[0]),
    .side      (st_side[0])
  );

  assign st_f[0] = '0;

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    vad_search_step #(
      .COORD_WIDTH (COORD_WIDTH),
      .STEP_BIT    (NSTEP - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[i]),
      .in_ready  (st_ready[i]),
      .u_in      (st_u[i]),
      .v_in      (st_v[i]),
      .f_in      (st_f[i]),
      .side_in   (st_side[i]),
      .out_valid (st_valid[i+1]),
      .out_ready (st_ready[i+1]),
      .u_out     (st_u[i+1]),
      .v_out     (st_v[i+1]),
      .f_out     (st_f[i+1]),
      .side_out  (st_side[i+1])
    );
  end

  vad_unfold u_unfold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[NSTEP]),
    .in_ready  (st_ready[NSTEP]),
    .f_in      (st_f[NSTEP]),
    .side_in   (st_side[NSTEP]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .angle_deg (angle_deg)
  );

  assign m_axis_tdata = {{(16 - vad_pkg::ANG_W){1'b0}}, angle_deg};

endmodule
